/* src/iogr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iogr_pkg
// Shared constants, item and configuration types for the occupancy grid
// rasterizer.
// ----------------------------------------------------------------------------
package iogr_pkg;

  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 256;
  localparam int MAX_RADIUS = 7;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int CRD_W   = 11;
  localparam int WIDE_W  = 13;
  localparam int ERR_W   = 16;
  localparam int DIM_W   = 9;
  localparam int CRAD_W  = 3;
  localparam int RAD_W   = 5;
  localparam int EDIM_W  = 11;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [1:0] REQ_RECT  = 2'd0;
  localparam logic [1:0] REQ_LINE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] OP_RECT  = 2'd0;
  localparam logic [1:0] OP_LINE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [CRD_W-1:0] x0;
    logic signed [CRD_W-1:0] y0;
    logic signed [CRD_W-1:0] x1;
    logic signed [CRD_W-1:0] y1;
  } item_t;

  typedef struct packed {
    logic [EDIM_W-1:0] eff_w;
    logic [EDIM_W-1:0] eff_h;
    logic [RAD_W-1:0]  eff_r;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

  function automatic logic signed [WIDE_W-1:0] sx(input logic signed [CRD_W-1:0] v);
    sx = {{(WIDE_W-CRD_W){v[CRD_W-1]}}, v};
  endfunction

endpackage

/* src/iogr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iogr_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module iogr_fifo import iogr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= push_item;
        wp_r        <= wp_r + 1'b1;
      end
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign head  = mem_r[rp_r];
  assign full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);

endmodule

/* src/iogr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iogr_front
// Accepts items and classifies them into operations for the back.
// ----------------------------------------------------------------------------
module iogr_front import iogr_pkg::*; (
  input  logic                    in_valid,
  input  logic                    stall,
  input  logic [1:0]              in_req_type,
  input  logic signed [CRD_W-1:0] in_x0,
  input  logic signed [CRD_W-1:0] in_y0,
  input  logic signed [CRD_W-1:0] in_x1,
  input  logic signed [CRD_W-1:0] in_y1,
  output logic                    push,
  output item_t                   push_item
);

  logic [1:0] op;

  always_comb begin
    unique case (in_req_type)
      REQ_RECT:  op = (in_x0 > in_x1 || in_y0 > in_y1) ? OP_NONE : OP_RECT;
      REQ_LINE:  op = OP_LINE;
      REQ_QUERY: op = OP_QUERY;
      default:   op = OP_NONE;
    endcase
  end

  assign push           = in_valid && !stall;
  assign push_item.op   = op;
  assign push_item.x0   = in_x0;
  assign push_item.y0   = in_y0;
  assign push_item.x1   = in_x1;
  assign push_item.y1   = in_y1;

endmodule

/* src/iogr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iogr_back
// Walks rectangles and line segments over the occupancy map, one column
// read-modify-write at a time, and answers queries.
// ----------------------------------------------------------------------------
module iogr_back import iogr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  item_t      head,
  input  logic       empty,
  output back_stat_t stat,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_blocked,
  output logic       out_outside
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_QRD   = 4'd2;
  localparam logic [3:0] S_PT    = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_STEP  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [MAX_ROWS-1:0] mem [MAX_COLS];
  logic [MAX_ROWS-1:0] rdata_r;
  logic [MAX_ROWS-1:0] ymask;

  logic [3:0]               state_r;
  logic [1:0]               op_r;
  logic signed [WIDE_W-1:0] cx_r, cy_r, ex_r, ey_r, dx_r, dy_r;
  logic                     sxn_r, syn_r;
  logic signed [ERR_W-1:0]  err_r;
  logic [COL_W-1:0]         col_r, colhi_r, clr_r;
  logic [ROW_W-1:0]         ylo_r, yhi_r, qy_r;
  logic                     res_blk_r, res_out_r, out_valid_r;

  logic signed [WIDE_W-1:0] r_s, w_s, h_s;
  logic signed [WIDE_W-1:0] bxl, bxh, byl, byh, cxl, cxh, cyl, cyh;
  logic                     box_ok;
  logic signed [WIDE_W-1:0] hx0, hy0, hx1, hy1, adx, ady;
  logic signed [ERR_W-1:0]  e2, nerr;
  logic                     slot_free, q_out;

  assign r_s = WIDE_W'(cfg.eff_r);
  assign w_s = WIDE_W'(cfg.eff_w);
  assign h_s = WIDE_W'(cfg.eff_h);
  assign hx0 = sx(head.x0);
  assign hy0 = sx(head.y0);
  assign hx1 = sx(head.x1);
  assign hy1 = sx(head.y1);
  assign adx = (hx1 > hx0) ? hx1 - hx0 : hx0 - hx1;
  assign ady = (hy1 > hy0) ? hy1 - hy0 : hy0 - hy1;

  always_comb begin
    if (state_r == S_IDLE) begin
      bxl = hx0 - r_s;
      bxh = hx1 + r_s;
      byl = hy0 - r_s;
      byh = hy1 + r_s;
    end else begin
      bxl = cx_r - r_s;
      bxh = cx_r + r_s;
      byl = cy_r - r_s;
      byh = cy_r + r_s;
    end
    cxl    = (bxl < 0) ? '0 : bxl;
    cyl    = (byl < 0) ? '0 : byl;
    cxh    = (bxh > w_s - WIDE_W'(1)) ? w_s - WIDE_W'(1) : bxh;
    cyh    = (byh > h_s - WIDE_W'(1)) ? h_s - WIDE_W'(1) : byh;
    box_ok = (cxl <= cxh) && (cyl <= cyh);
  end

  always_comb begin
    for (int j = 0; j < MAX_ROWS; j++) begin
      ymask[j] = (ROW_W'(j) >= ylo_r) && (ROW_W'(j) <= yhi_r);
    end
  end

  assign e2 = err_r <<< 1;
  always_comb begin
    nerr = err_r;
    if (e2 >= ERR_W'(dy_r)) nerr = nerr + ERR_W'(dy_r);
    if (e2 <= ERR_W'(dx_r)) nerr = nerr + ERR_W'(dx_r);
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign q_out = (hx0 < 0) || (hx0 >= w_s) || (hy0 < 0) || (hy0 >= h_s);

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) mem[clr_r] <= '0;
    else if (state_r == S_WR) mem[col_r] <= rdata_r | ymask;
    if (state_r == S_IDLE) rdata_r <= mem[hx0[COL_W-1:0]];
    else if (state_r == S_RD) rdata_r <= mem[col_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == COL_W'(MAX_COLS-1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (!empty) begin
            op_r      <= head.op;
            res_blk_r <= 1'b0;
            res_out_r <= 1'b0;
            qy_r      <= hy0[ROW_W-1:0];
            cx_r      <= hx0;
            cy_r      <= hy0;
            ex_r      <= hx1;
            ey_r      <= hy1;
            dx_r      <= adx;
            dy_r      <= -ady;
            sxn_r     <= !(hx0 < hx1);
            syn_r     <= !(hy0 < hy1);
            err_r     <= ERR_W'(adx) - ERR_W'(ady);
            col_r     <= cxl[COL_W-1:0];
            colhi_r   <= cxh[COL_W-1:0];
            ylo_r     <= cyl[ROW_W-1:0];
            yhi_r     <= cyh[ROW_W-1:0];
            unique case (head.op)
              OP_RECT:  state_r <= box_ok ? S_RD : S_DONE;
              OP_LINE:  state_r <= S_PT;
              OP_QUERY: begin
                if (q_out) begin
                  res_blk_r <= 1'b1;
                  res_out_r <= 1'b1;
                  state_r   <= S_DONE;
                end else begin
                  state_r <= S_QRD;
                end
              end
              default:  state_r <= S_DONE;
            endcase
          end
        end
        S_QRD: begin
          res_blk_r <= rdata_r[qy_r];
          state_r   <= S_DONE;
        end
        S_PT: begin
          col_r   <= cxl[COL_W-1:0];
          colhi_r <= cxh[COL_W-1:0];
          ylo_r   <= cyl[ROW_W-1:0];
          yhi_r   <= cyh[ROW_W-1:0];
          state_r <= box_ok ? S_RD : S_STEP;
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          if (col_r == colhi_r) begin
            state_r <= (op_r == OP_LINE) ? S_STEP : S_DONE;
          end else begin
            col_r   <= col_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_STEP: begin
          if (cx_r == ex_r && cy_r == ey_r) begin
            state_r <= S_DONE;
          end else begin
            err_r <= nerr;
            if (e2 >= ERR_W'(dy_r)) cx_r <= sxn_r ? cx_r - WIDE_W'(1) : cx_r + WIDE_W'(1);
            if (e2 <= ERR_W'(dx_r)) cy_r <= syn_r ? cy_r - WIDE_W'(1) : cy_r + WIDE_W'(1);
            state_r <= S_PT;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_blocked <= res_blk_r;
            out_outside <= res_out_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign stat.clearing = (state_r == S_CLEAR);
  assign stat.pop      = (state_r == S_IDLE) && !empty;
  assign out_valid     = out_valid_r;

endmodule

/* src/inflated_occupancy_grid_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inflated_occupancy_grid_rasterizer
// One-bit occupancy map with inflated rectangle and line marking and
// cell queries.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   req_type, x0, y0, x1, y1
//   out_      output     out_valid/out_stall blocked, outside
//   APB       input      psel/penable        grid_width, height, radius
//
// A query reads one map column and picks its cell; a mark reads and
// writes back each column of each inflated box, and a line steps from
// point to point. After reset a clearing pass over all 256 map columns
// runs with in_stall high. Items queue four deep in front of the back
// end, and one result waits in the output register.
// ----------------------------------------------------------------------------
module inflated_occupancy_grid_rasterizer import iogr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_req_type,
  input  logic signed [CRD_W-1:0] in_x0,
  input  logic signed [CRD_W-1:0] in_y0,
  input  logic signed [CRD_W-1:0] in_x1,
  input  logic signed [CRD_W-1:0] in_y1,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_blocked,
  output logic                    out_outside,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [DIM_W-1:0]  width_r, height_r;
  logic [CRAD_W-1:0] radius_r;
  cfg_t              cfg;
  item_t             push_item, head;
  logic              push, full, empty;
  back_stat_t        stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(256);
      height_r <= DIM_W'(256);
      radius_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_RADIUS: radius_r <= pwdata[CRAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_RADIUS: prdata = 32'(radius_r);
      default:    prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  assign cfg.eff_w = (EDIM_W'(width_r) > EDIM_W'(MAX_COLS)) ?
                     EDIM_W'(MAX_COLS) : EDIM_W'(width_r);
  assign cfg.eff_h = (EDIM_W'(height_r) > EDIM_W'(MAX_ROWS)) ?
                     EDIM_W'(MAX_ROWS) : EDIM_W'(height_r);
  assign cfg.eff_r = (RAD_W'(radius_r) > RAD_W'(MAX_RADIUS)) ?
                     RAD_W'(MAX_RADIUS) : RAD_W'(radius_r);

  assign in_stall = full || stat.clearing;

  iogr_front u_front (
    .in_valid    (in_valid),
    .stall       (in_stall),
    .in_req_type (in_req_type),
    .in_x0       (in_x0),
    .in_y0       (in_y0),
    .in_x1       (in_x1),
    .in_y1       (in_y1),
    .push        (push),
    .push_item   (push_item)
  );

  iogr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (stat.pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  iogr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .head        (head),
    .empty       (empty),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_blocked (out_blocked),
    .out_outside (out_outside)
  );

endmodule
